/* src/mrs_pkg.sv */
// Shared types, codes and the CRC-16 byte update for the Modbus RTU slave engine.
`default_nettype none
package mrs_pkg;

    // Input word modes
    localparam logic [1:0] MODE_BUS = 2'd0;
    localparam logic [1:0] MODE_REG = 2'd1;
    localparam logic [1:0] MODE_BIT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_DEV      = 3'd0;
    localparam logic [2:0] REG_COIL     = 3'd1;
    localparam logic [2:0] REG_DISCRETE = 3'd2;
    localparam logic [2:0] REG_HOLDING  = 3'd3;
    localparam logic [2:0] REG_INPUT    = 3'd4;

    // Function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
    localparam logic [7:0] FC_EXC_FLAG      = 8'h80;

    // Exception codes
    localparam logic [7:0] EXC_ADDR  = 8'd2;
    localparam logic [7:0] EXC_VALUE = 8'd3;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Job kinds in the queue
    localparam logic [1:0] JOB_FRAME   = 2'd0;
    localparam logic [1:0] JOB_LOC_REG = 2'd1;
    localparam logic [1:0] JOB_LOC_BIT = 2'd2;

    typedef struct packed {
        logic [7:0]  dev;
        logic [15:0] coil_base;
        logic [15:0] discrete_base;
        logic [15:0] holding_base;
        logic [15:0] input_base;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [7:0]  bc;
        logic [5:0]  idx;
        logic [15:0] val;
    } job_t;

    // Bytewise reflected CRC-16 update
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/mrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/mrs_front.sv */
// Front end: frame gathering, CRC check, classification and the job queue.
`default_nettype none
module mrs_front import mrs_pkg::*; #(
    parameter int FRAME_BYTES = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_mode,
    input  wire logic [7:0]                     s_rx_byte,
    input  wire logic [5:0]                     s_local_index,
    input  wire logic [15:0]                    s_local_value,
    input  wire logic [7:0]                     dev,
    input  wire logic                           cfg_drop,
    output logic                                ram_we,
    output logic [$clog2(FRAME_BYTES)-1:0]      ram_waddr,
    output logic [7:0]                          ram_wdata,
    output logic                                job_valid,
    output job_t                                job,
    input  wire logic                           job_pop,
    input  wire logic                           frame_done
);
    localparam int AW   = $clog2(FRAME_BYTES);
    localparam int CNTW = $clog2(FRAME_BYTES + 1);

    logic [CNTW-1:0] count_reg, count_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      fc_reg, fc_next;
    logic [7:0]      ahi_reg, ahi_next, alo_reg, alo_next;
    logic [7:0]      qhi_reg, qhi_next, qlo_reg, qlo_next;
    logic [7:0]      bc_reg, bc_next;
    logic            busy_reg, busy_next;

    job_t            qmem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      qcnt_reg;

    logic            accept, push;
    job_t            push_job;

    logic [CNTW-1:0] cnt_inc;
    logic [15:0]     crc_upd;
    logic [7:0]      fc_cur, bc_cur;
    logic [9:0]      needed;
    logic            fc_ok, fc_multi;

    assign s_ready   = (qcnt_reg != 2'd2) && !busy_reg;
    assign accept    = s_valid && s_ready;
    assign job_valid = (qcnt_reg != 2'd0);
    assign job       = qmem_reg[rd_ptr_reg];

    assign cnt_inc   = count_reg + CNTW'(1);
    assign crc_upd   = crc16_byte(crc_reg, s_rx_byte);
    assign fc_cur    = (count_reg == CNTW'(1)) ? s_rx_byte : fc_reg;
    assign bc_cur    = (count_reg == CNTW'(6)) ? s_rx_byte : bc_reg;
    assign needed    = 10'd9 + {2'b00, bc_cur};
    assign fc_multi  = (fc_cur == FC_WRITE_COILS) || (fc_cur == FC_WRITE_REGS);
    assign fc_ok     = ((fc_cur >= FC_READ_COILS) && (fc_cur <= FC_WRITE_REG)) || fc_multi;

    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = s_rx_byte;

    // Frame assembly and classification
    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        fc_next    = fc_reg;
        ahi_next   = ahi_reg;
        alo_next   = alo_reg;
        qhi_next   = qhi_reg;
        qlo_next   = qlo_reg;
        bc_next    = bc_reg;
        busy_next  = busy_reg;
        ram_we     = 1'b0;
        push       = 1'b0;
        push_job   = '{kind: JOB_FRAME, fc: fc_reg, addr: {ahi_reg, alo_reg},
                       qty: {qhi_reg, qlo_reg}, bc: bc_cur, idx: s_local_index,
                       val: s_local_value};
        if (frame_done) begin
            busy_next = 1'b0;
        end
        if (cfg_drop) begin
            count_next = '0;
            crc_next   = CRC_INIT;
        end else if (accept) begin
            case (s_mode)
                MODE_BUS: begin
                    if (count_reg == '0 && s_rx_byte != dev) begin
                        count_next = count_reg;
                    end else if ({{(10-CNTW){1'b0}}, count_reg} >= 10'(FRAME_BYTES)) begin
                        count_next = '0;
                        crc_next   = CRC_INIT;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = cnt_inc;
                        crc_next   = crc_upd;
                        case (count_reg)
                            CNTW'(1): fc_next  = s_rx_byte;
                            CNTW'(2): ahi_next = s_rx_byte;
                            CNTW'(3): alo_next = s_rx_byte;
                            CNTW'(4): qhi_next = s_rx_byte;
                            CNTW'(5): qlo_next = s_rx_byte;
                            CNTW'(6): bc_next  = s_rx_byte;
                            default: ;
                        endcase
                        if (cnt_inc >= CNTW'(2)) begin
                            if (!fc_ok) begin
                                count_next = '0;
                                crc_next   = CRC_INIT;
                            end else if (fc_multi) begin
                                if (cnt_inc >= CNTW'(7)) begin
                                    if (needed > 10'(FRAME_BYTES)) begin
                                        count_next = '0;
                                        crc_next   = CRC_INIT;
                                    end else if ({{(10-CNTW){1'b0}}, cnt_inc} >= needed) begin
                                        count_next = '0;
                                        crc_next   = CRC_INIT;
                                        if (crc_upd == 16'h0000) begin
                                            push      = 1'b1;
                                            busy_next = 1'b1;
                                        end
                                    end
                                end
                            end else if (cnt_inc >= CNTW'(8)) begin
                                count_next = '0;
                                crc_next   = CRC_INIT;
                                if (crc_upd == 16'h0000) begin
                                    push      = 1'b1;
                                    busy_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                MODE_REG: begin
                    push          = 1'b1;
                    push_job.kind = JOB_LOC_REG;
                end
                MODE_BIT: begin
                    push          = 1'b1;
                    push_job.kind = JOB_LOC_BIT;
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            crc_reg    <= CRC_INIT;
            busy_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            qcnt_reg   <= 2'd0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            busy_reg  <= busy_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (job_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            qcnt_reg <= qcnt_reg + {1'b0, push} - {1'b0, job_pop};
        end
    end

    // Header capture and queue storage
    always_ff @(posedge aclk) begin
        fc_reg  <= fc_next;
        ahi_reg <= ahi_next;
        alo_reg <= alo_next;
        qhi_reg <= qhi_next;
        qlo_reg <= qlo_next;
        bc_reg  <= bc_next;
        if (push) begin
            qmem_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

/* src/mrs_back.sv */
// Back end: request checks, data stores, store updates and reply generation.
`default_nettype none
module mrs_back import mrs_pkg::*; #(
    parameter int COIL_COUNT      = 64,
    parameter int DISCRETE_COUNT  = 64,
    parameter int HOLDING_COUNT   = 16,
    parameter int INPUT_REG_COUNT = 16,
    parameter int FRAME_BYTES     = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cfg_t                       cfg,
    input  wire logic                       job_valid,
    input  wire job_t                       job,
    output logic                            job_pop,
    output logic                            frame_done,
    output logic [$clog2(FRAME_BYTES)-1:0]  ram_raddr,
    input  wire logic [7:0]                 ram_rdata,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_tx_byte,
    output logic                            m_last_byte
);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(COIL_COUNT);
    localparam int DW = $clog2(DISCRETE_COUNT);
    localparam int HW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int IW = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_WRD   = 3'd2;
    localparam logic [2:0] ST_WRW   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] RSP_EXC  = 2'd0;
    localparam logic [1:0] RSP_ECHO = 2'd1;
    localparam logic [1:0] RSP_BITS = 2'd2;
    localparam logic [1:0] RSP_REGS = 2'd3;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  fc_reg, fc_next;
    logic [15:0] a_reg, a_next, q_reg, q_next;
    logic [7:0]  bc_reg, bc_next;
    logic [1:0]  rsp_reg, rsp_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  j_reg, j_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] crc_reg, crc_next;

    logic [COIL_COUNT-1:0]     coil_reg, coil_next;
    logic [DISCRETE_COUNT-1:0] disc_reg, disc_next;
    logic [15:0] hold_reg [HOLDING_COUNT];
    logic [15:0] hold_next [HOLDING_COUNT];
    logic [15:0] inreg_reg [INPUT_REG_COUNT];
    logic [15:0] inreg_next [INPUT_REG_COUNT];

    logic        mv_reg, mv_next, ml_reg, ml_next;
    logic [7:0]  mb_reg, mb_next;

    // Range check operands
    logic [15:0] base_sel;
    logic [17:0] size_sel, n_sel;
    logic        rng_ok;
    logic [13:0] nbytes;
    logic [16:0] twice_q;

    // Reply byte generation
    logic [7:0]  dj;
    logic [9:0]  bitpos;
    logic [16:0] bitnum;
    logic [7:0]  bits_byte;
    logic [7:0]  ri;
    logic [15:0] rval;
    logic [7:0]  gen_byte;
    logic        load_out;

    // Multiple-write helpers
    logic [9:0]  wpos;
    logic [16:0] wnum;
    logic [7:0]  wri;

    assign m_valid     = mv_reg;
    assign m_tx_byte   = mb_reg;
    assign m_last_byte = ml_reg;
    assign ram_raddr   = AW'(9'd7 + {1'b0, j_reg});
    assign load_out    = !mv_reg || m_ready;

    assign nbytes  = 14'((17'(q_reg) + 17'd7) >> 3);
    assign twice_q = {q_reg, 1'b0};

    // Store, base and width for the request
    always_comb begin
        base_sel = cfg.coil_base;
        size_sel = 18'(COIL_COUNT);
        n_sel    = {2'b00, q_reg};
        case (fc_reg)
            FC_READ_COILS, FC_WRITE_COILS: begin
                base_sel = cfg.coil_base;
                size_sel = 18'(COIL_COUNT);
            end
            FC_READ_DISCRETE: begin
                base_sel = cfg.discrete_base;
                size_sel = 18'(DISCRETE_COUNT);
            end
            FC_READ_HOLDING, FC_WRITE_REGS: begin
                base_sel = cfg.holding_base;
                size_sel = 18'(HOLDING_COUNT);
            end
            FC_READ_INPUT: begin
                base_sel = cfg.input_base;
                size_sel = 18'(INPUT_REG_COUNT);
            end
            FC_WRITE_COIL: begin
                base_sel = cfg.coil_base;
                size_sel = 18'(COIL_COUNT);
                n_sel    = 18'd1;
            end
            FC_WRITE_REG: begin
                base_sel = cfg.holding_base;
                size_sel = 18'(HOLDING_COUNT);
                n_sel    = 18'd1;
            end
            default: ;
        endcase
        rng_ok = (a_reg >= base_sel) &&
                 ({2'b00, a_reg} + n_sel <= {2'b00, base_sel} + size_sel);
    end

    // Data byte of a read reply
    always_comb begin
        dj     = idx_reg - 8'd3;
        bitpos = {2'b00, off_reg} + {dj[6:0], 3'b000};
        for (int b = 0; b < 8; b++) begin
            bitnum       = {6'd0, dj, 3'b000} + 17'(b);
            bits_byte[b] = 1'b0;
            if (bitnum < {1'b0, q_reg}) begin
                if (fc_reg == FC_READ_COILS) begin
                    if (bitpos + 10'(b) < 10'(COIL_COUNT)) begin
                        bits_byte[b] = coil_reg[CW'(bitpos + 10'(b))];
                    end
                end else if (bitpos + 10'(b) < 10'(DISCRETE_COUNT)) begin
                    bits_byte[b] = disc_reg[DW'(bitpos + 10'(b))];
                end
            end
        end
        ri   = off_reg + {1'b0, dj[7:1]};
        rval = 16'h0000;
        if (fc_reg == FC_READ_HOLDING) begin
            if (ri < 8'(HOLDING_COUNT)) begin
                rval = hold_reg[HW'(ri)];
            end
        end else if (ri < 8'(INPUT_REG_COUNT)) begin
            rval = inreg_reg[IW'(ri)];
        end
    end

    // Reply byte at the current position
    always_comb begin
        gen_byte = cfg.dev;
        case (idx_reg)
            8'd0: gen_byte = cfg.dev;
            8'd1: gen_byte = (rsp_reg == RSP_EXC) ? (fc_reg | FC_EXC_FLAG) : fc_reg;
            8'd2: begin
                case (rsp_reg)
                    RSP_EXC:  gen_byte = code_reg;
                    RSP_ECHO: gen_byte = a_reg[15:8];
                    default:  gen_byte = len_reg - 8'd3;
                endcase
            end
            default: begin
                case (rsp_reg)
                    RSP_ECHO: begin
                        case (idx_reg)
                            8'd3:    gen_byte = a_reg[7:0];
                            8'd4:    gen_byte = q_reg[15:8];
                            default: gen_byte = q_reg[7:0];
                        endcase
                    end
                    RSP_BITS: gen_byte = bits_byte;
                    RSP_REGS: gen_byte = dj[0] ? rval[7:0] : rval[15:8];
                    default:  gen_byte = code_reg;
                endcase
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        fc_next    = fc_reg;
        a_next     = a_reg;
        q_next     = q_reg;
        bc_next    = bc_reg;
        rsp_next   = rsp_reg;
        code_next  = code_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        hi_next    = hi_reg;
        crc_next   = crc_reg;
        coil_next  = coil_reg;
        disc_next  = disc_reg;
        hold_next  = hold_reg;
        inreg_next = inreg_reg;
        mv_next    = mv_reg;
        mb_next    = mb_reg;
        ml_next    = ml_reg;
        job_pop    = 1'b0;
        frame_done = 1'b0;
        wpos       = '0;
        wnum       = '0;
        wri        = '0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop = 1'b1;
                    case (job.kind)
                        JOB_LOC_REG: begin
                            if ({2'b00, job.idx} < 8'(INPUT_REG_COUNT)) begin
                                inreg_next[IW'(job.idx)] = job.val;
                            end
                        end
                        JOB_LOC_BIT: begin
                            if ({3'b000, job.idx} < 9'(DISCRETE_COUNT)) begin
                                disc_next[DW'(job.idx)] = job.val[0];
                            end
                        end
                        default: begin
                            fc_next    = job.fc;
                            a_next     = job.addr;
                            q_next     = job.qty;
                            bc_next    = job.bc;
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                off_next   = 8'(a_reg - base_sel);
                idx_next   = 8'd0;
                j_next     = 8'd0;
                crc_next   = CRC_INIT;
                state_next = ST_EMIT;
                rsp_next   = RSP_ECHO;
                len_next   = 8'd6;
                if (!rng_ok) begin
                    rsp_next  = RSP_EXC;
                    code_next = EXC_ADDR;
                    len_next  = 8'd3;
                end else begin
                    case (fc_reg)
                        FC_READ_COILS, FC_READ_DISCRETE: begin
                            rsp_next = RSP_BITS;
                            len_next = 8'd3 + nbytes[7:0];
                        end
                        FC_READ_HOLDING, FC_READ_INPUT: begin
                            rsp_next = RSP_REGS;
                            len_next = 8'd3 + twice_q[7:0];
                        end
                        FC_WRITE_COIL: begin
                            if (q_reg == COIL_ON) begin
                                coil_next[CW'(a_reg - cfg.coil_base)] = 1'b1;
                            end else if (q_reg == COIL_OFF) begin
                                coil_next[CW'(a_reg - cfg.coil_base)] = 1'b0;
                            end else begin
                                rsp_next  = RSP_EXC;
                                code_next = EXC_VALUE;
                                len_next  = 8'd3;
                            end
                        end
                        FC_WRITE_REG: begin
                            hold_next[HW'(a_reg - cfg.holding_base)] = q_reg;
                        end
                        FC_WRITE_COILS: begin
                            if ({6'd0, bc_reg} != nbytes) begin
                                rsp_next  = RSP_EXC;
                                code_next = EXC_VALUE;
                                len_next  = 8'd3;
                            end else if (bc_reg != 8'd0) begin
                                state_next = ST_WRD;
                            end
                        end
                        FC_WRITE_REGS: begin
                            if ({9'd0, bc_reg} != twice_q) begin
                                rsp_next  = RSP_EXC;
                                code_next = EXC_VALUE;
                                len_next  = 8'd3;
                            end else if (bc_reg != 8'd0) begin
                                state_next = ST_WRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WRD: begin
                // Frame byte address is presented; data arrives next cycle
                state_next = ST_WRW;
            end
            ST_WRW: begin
                if (fc_reg == FC_WRITE_COILS) begin
                    for (int b = 0; b < 8; b++) begin
                        wnum = {6'd0, j_reg, 3'b000} + 17'(b);
                        wpos = {2'b00, off_reg} + wnum[9:0];
                        if (wnum < {1'b0, q_reg} && wpos < 10'(COIL_COUNT)) begin
                            coil_next[CW'(wpos)] = ram_rdata[b];
                        end
                    end
                end else if (!j_reg[0]) begin
                    hi_next = ram_rdata;
                end else begin
                    wri = off_reg + {1'b0, j_reg[7:1]};
                    if (wri < 8'(HOLDING_COUNT)) begin
                        hold_next[HW'(wri)] = {hi_reg, ram_rdata};
                    end
                end
                j_next = j_reg + 8'd1;
                if (j_reg + 8'd1 == bc_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_WRD;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    mv_next  = 1'b1;
                    idx_next = idx_reg + 8'd1;
                    ml_next  = 1'b0;
                    if (idx_reg < len_reg) begin
                        mb_next  = gen_byte;
                        crc_next = crc16_byte(crc_reg, gen_byte);
                    end else if (idx_reg == len_reg) begin
                        mb_next = crc_reg[7:0];
                    end else begin
                        mb_next    = crc_reg[15:8];
                        ml_next    = 1'b1;
                        frame_done = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and stores with a reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            coil_reg  <= '0;
            disc_reg  <= '0;
            for (int i = 0; i < HOLDING_COUNT; i++) begin
                hold_reg[i] <= '0;
            end
            for (int i = 0; i < INPUT_REG_COUNT; i++) begin
                inreg_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            coil_reg  <= coil_next;
            disc_reg  <= disc_next;
            hold_reg  <= hold_next;
            inreg_reg <= inreg_next;
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        fc_reg   <= fc_next;
        a_reg    <= a_next;
        q_reg    <= q_next;
        bc_reg   <= bc_next;
        rsp_reg  <= rsp_next;
        code_reg <= code_next;
        off_reg  <= off_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        hi_reg   <= hi_next;
        crc_reg  <= crc_next;
        mb_reg   <= mb_next;
        ml_reg   <= ml_next;
    end
endmodule
`default_nettype wire

/* src/modbus_rtu_slave_engine.sv */
// Top level of the Modbus RTU slave engine: configuration, front, queue, back.
//
//  Channel   Direction  Handshake           Word
//  s_        in         s_valid / s_ready   mode, rx byte, local index, local value
//  m_        out        m_valid / m_ready   reply byte, last-byte flag
//  cfg_      in         cfg_wr_en           register index, write data
//
// A bus byte or local write is taken while the job queue has room and no good frame
// is pending. A good frame holds the input until its last reply byte is loaded: checks,
// a frame buffer read for each data byte of a multiple write, then one reply byte per
// cycle while m_ready is high. Reset (aresetn low, synchronous) clears all stores.
// The output register lets the back end run ahead by one byte of a stalled consumer.
`default_nettype none
module modbus_rtu_slave_engine import mrs_pkg::*; #(
    parameter int COIL_COUNT      = 64,
    parameter int DISCRETE_COUNT  = 64,
    parameter int HOLDING_COUNT   = 16,
    parameter int INPUT_REG_COUNT = 16,
    parameter int FRAME_BYTES     = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [5:0]  s_local_index,
    input  wire logic [15:0] s_local_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_tx_byte,
    output logic             m_last_byte,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    localparam int AW = $clog2(FRAME_BYTES);

    cfg_t          cfg_reg;
    logic          cfg_drop;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          job_valid, job_pop, frame_done;
    job_t          job;

    assign cfg_drop = cfg_wr_en && (cfg_index == REG_DEV);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{dev: 8'd1, coil_base: 16'd0, discrete_base: 16'd0,
                         holding_base: 16'd0, input_base: 16'd0};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEV:      cfg_reg.dev           <= cfg_wdata[7:0];
                REG_COIL:     cfg_reg.coil_base     <= cfg_wdata;
                REG_DISCRETE: cfg_reg.discrete_base <= cfg_wdata;
                REG_HOLDING:  cfg_reg.holding_base  <= cfg_wdata;
                REG_INPUT:    cfg_reg.input_base    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_rx_byte     (s_rx_byte),
        .s_local_index (s_local_index),
        .s_local_value (s_local_value),
        .dev           (cfg_reg.dev),
        .cfg_drop      (cfg_drop),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .job_valid     (job_valid),
        .job           (job),
        .job_pop       (job_pop),
        .frame_done    (frame_done)
    );

    mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mrs_back #(
        .COIL_COUNT      (COIL_COUNT),
        .DISCRETE_COUNT  (DISCRETE_COUNT),
        .HOLDING_COUNT   (HOLDING_COUNT),
        .INPUT_REG_COUNT (INPUT_REG_COUNT),
        .FRAME_BYTES     (FRAME_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .job_valid   (job_valid),
        .job         (job),
        .job_pop     (job_pop),
        .frame_done  (frame_done),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_byte   (m_tx_byte),
        .m_last_byte (m_last_byte)
    );
endmodule
`default_nettype wire
